@@ rtl/pvsd_pkg.sv @@
// Shared types, widths and constants of the peak/valley step detector.
package pvsd_pkg;

   localparam int unsigned WINDOW_LEN = 8;
   localparam int unsigned PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int unsigned DEV_W = 13;
   localparam int unsigned SUM_W = DEV_W + $clog2(WINDOW_LEN);
   localparam int unsigned LVL_W = 17;
   localparam int unsigned ACC_W = 12;
   localparam int unsigned GRAV_W = 16;
   localparam int unsigned MUL_W = 28;
   localparam int unsigned DOT_W = 30;
   localparam int unsigned PROJ_W = 16;
   localparam int unsigned DIFF_W = 17;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned CNT_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_TDATA_W = 72;
   localparam int unsigned RSP_TDATA_W = 56;

   // floor(x / WINDOW_LEN) as (x * DIV_MUL) >> DIV_SH, exact for x < 2^17 * WINDOW_LEN
   localparam int unsigned DIV_SH = 29;
   localparam int unsigned DIVX_W = SUM_W + 4;
   localparam int unsigned DIVP_W = DIVX_W + DIV_SH;
   localparam logic [DIV_SH-1:0] DIV_MUL =
      DIV_SH'(((64'd1 << DIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

   localparam logic [DEV_W-1:0] DEV_MAX = '1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GRAV_X      = 3'd0,
      CSR_GRAV_Y      = 3'd1,
      CSR_GRAV_Z      = 3'd2,
      CSR_REST_LEVEL  = 3'd3,
      CSR_QUIET_BAND  = 3'd4,
      CSR_MIN_SWING   = 3'd5,
      CSR_GAP_LO      = 3'd6,
      CSR_GAP_HI      = 3'd7
   } csr_idx_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_CLEAR  = 1'b1
   } kind_type;

   typedef struct packed {
      logic signed [GRAV_W-1:0] grav_x;
      logic signed [GRAV_W-1:0] grav_y;
      logic signed [GRAV_W-1:0] grav_z;
      logic signed [DEV_W-1:0]  rest_level;
      logic [DEV_W-1:0]         quiet_band;
      logic [DEV_W-1:0]         min_swing;
      logic [15:0]              gap_lo_ms;
      logic [15:0]              gap_hi_ms;
   } cfg_type;

   typedef struct packed {
      kind_type                kind;
      logic signed [ACC_W-1:0] accel_x;
      logic signed [ACC_W-1:0] accel_y;
      logic signed [ACC_W-1:0] accel_z;
      logic [TIME_W-1:0]       time_ms;
   } sample_type;

   typedef struct packed {
      kind_type          kind;
      logic [TIME_W-1:0] time_ms;
      logic [DEV_W-1:0]  dev;
   } dev_type;

   typedef struct packed {
      kind_type          kind;
      logic [TIME_W-1:0] time_ms;
      logic [LVL_W-1:0]  level;
   } lvl_type;

   // packed so that the whole struct is the low bits of the result tdata
   typedef struct packed {
      logic [LVL_W-1:0] smoothed_level;
      logic             step_now;
      logic [CNT_W-1:0] step_total;
   } rsp_type;

endpackage

@@ rtl/pvsd_front.sv @@
// Projection onto the gravity vector and rest-level deviation, three stages.
module pvsd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  pvsd_pkg::cfg_type    cfg,
   input  logic                 in_vld,
   output logic                 in_rdy,
   input  pvsd_pkg::sample_type in_beat,
   output logic                 out_vld,
   input  logic                 out_rdy,
   output pvsd_pkg::dev_type    out_beat
);

   typedef struct packed {
      pvsd_pkg::kind_type                 kind;
      logic [pvsd_pkg::TIME_W-1:0]        time_ms;
      logic signed [pvsd_pkg::MUL_W-1:0]  px;
      logic signed [pvsd_pkg::MUL_W-1:0]  py;
      logic signed [pvsd_pkg::MUL_W-1:0]  pz;
   } s1_type;

   typedef struct packed {
      pvsd_pkg::kind_type                 kind;
      logic [pvsd_pkg::TIME_W-1:0]        time_ms;
      logic signed [pvsd_pkg::PROJ_W-1:0] proj;
   } s2_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   pvsd_pkg::dev_type s3_ff, s3_in;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy;

   logic signed [pvsd_pkg::DOT_W-1:0]  dot;
   logic signed [pvsd_pkg::DIFF_W-1:0] diff;
   logic [pvsd_pkg::DIFF_W-1:0]        mag;

   assign s3_rdy = !s3_vld_ff || out_rdy;
   assign s2_rdy = !s2_vld_ff || s3_rdy;
   assign s1_rdy = !s1_vld_ff || s2_rdy;
   assign in_rdy = s1_rdy;

   always_comb begin
      s1_in.kind    = in_beat.kind;
      s1_in.time_ms = in_beat.time_ms;
      s1_in.px = pvsd_pkg::MUL_W'(in_beat.accel_x) * pvsd_pkg::MUL_W'(cfg.grav_x);
      s1_in.py = pvsd_pkg::MUL_W'(in_beat.accel_y) * pvsd_pkg::MUL_W'(cfg.grav_y);
      s1_in.pz = pvsd_pkg::MUL_W'(in_beat.accel_z) * pvsd_pkg::MUL_W'(cfg.grav_z);
   end

   // round to nearest, ties upward: add half an LSB and take the floor
   always_comb begin
      dot = pvsd_pkg::DOT_W'(s1_ff.px) + pvsd_pkg::DOT_W'(s1_ff.py)
          + pvsd_pkg::DOT_W'(s1_ff.pz) + pvsd_pkg::DOT_W'(8192);
      s2_in.kind    = s1_ff.kind;
      s2_in.time_ms = s1_ff.time_ms;
      s2_in.proj    = dot[pvsd_pkg::DOT_W-1:14];
   end

   always_comb begin
      diff = pvsd_pkg::DIFF_W'(s2_ff.proj) - pvsd_pkg::DIFF_W'(cfg.rest_level);
      mag  = diff[pvsd_pkg::DIFF_W-1] ? pvsd_pkg::DIFF_W'(-diff) : pvsd_pkg::DIFF_W'(diff);
      s3_in.kind    = s2_ff.kind;
      s3_in.time_ms = s2_ff.time_ms;
      if (mag < pvsd_pkg::DIFF_W'(cfg.quiet_band)) begin
         s3_in.dev = '0;
      end else if (mag > pvsd_pkg::DIFF_W'(pvsd_pkg::DEV_MAX)) begin
         s3_in.dev = pvsd_pkg::DEV_MAX;
      end else begin
         s3_in.dev = mag[pvsd_pkg::DEV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_ff <= s1_in;
      end
      if (s2_rdy) begin
         s2_ff <= s2_in;
      end
      if (s3_rdy) begin
         s3_ff <= s3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= in_vld;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_rdy) begin
            s3_vld_ff <= s2_vld_ff;
         end
      end
   end

   assign out_vld  = s3_vld_ff;
   assign out_beat = s3_ff;

endmodule

@@ rtl/pvsd_wmem.sv @@
// Window store: synchronous memory with registered read and per-entry valid bits.
module pvsd_wmem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [pvsd_pkg::PTR_W-1:0]   rd_addr,
   output logic [pvsd_pkg::DEV_W-1:0]   rd_data,
   input  logic                         wr_en,
   input  logic [pvsd_pkg::PTR_W-1:0]   wr_addr,
   input  logic [pvsd_pkg::DEV_W-1:0]   wr_data
);

   logic [pvsd_pkg::DEV_W-1:0]      store [pvsd_pkg::WINDOW_LEN];
   logic [pvsd_pkg::WINDOW_LEN-1:0] vld_ff;
   logic [pvsd_pkg::DEV_W-1:0]      rd_raw_ff;
   logic                            rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // an entry never written since reset reads as zero
   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

@@ rtl/pvsd_window.sv @@
// Moving-average window: store read, running-sum update and write-back, scaling.
module pvsd_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   output logic               in_rdy,
   input  pvsd_pkg::dev_type  in_beat,
   output logic               out_vld,
   input  logic               out_rdy,
   output pvsd_pkg::lvl_type  out_beat
);

   typedef struct packed {
      pvsd_pkg::kind_type            kind;
      logic [pvsd_pkg::TIME_W-1:0]   time_ms;
      logic [pvsd_pkg::DEV_W-1:0]    dev;
      logic [pvsd_pkg::PTR_W-1:0]    addr;
   } s4_type;

   typedef struct packed {
      pvsd_pkg::kind_type            kind;
      logic [pvsd_pkg::TIME_W-1:0]   time_ms;
      logic [pvsd_pkg::SUM_W-1:0]    sum;
   } s5_type;

   typedef struct packed {
      pvsd_pkg::kind_type            kind;
      logic [pvsd_pkg::TIME_W-1:0]   time_ms;
      logic [pvsd_pkg::DIVP_W-1:0]   prod;
   } s6_type;

   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   logic s4_vld_ff, s5_vld_ff, s6_vld_ff;
   logic s4_rdy, s5_rdy, s6_rdy;

   logic [pvsd_pkg::PTR_W-1:0] rptr_ff, rptr_in;
   logic [pvsd_pkg::SUM_W-1:0] sum_ff;
   logic [pvsd_pkg::DEV_W-1:0] old_dev;
   logic                       rd_en;
   logic                       commit;

   assign s6_rdy = !s6_vld_ff || out_rdy;
   assign s5_rdy = !s5_vld_ff || s6_rdy;
   assign s4_rdy = !s4_vld_ff || s5_rdy;
   assign in_rdy = s4_rdy;

   // read the entry this sample replaces as it enters the read stage
   assign rd_en  = s4_rdy && in_vld;
   assign commit = s5_rdy && s4_vld_ff && (s4_ff.kind == pvsd_pkg::KIND_SAMPLE);

   pvsd_wmem u_wmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rptr_ff),
      .rd_data (old_dev),
      .wr_en   (commit),
      .wr_addr (s4_ff.addr),
      .wr_data (s4_ff.dev)
   );

   always_comb begin
      rptr_in = rptr_ff;
      if (rd_en && (in_beat.kind == pvsd_pkg::KIND_SAMPLE)) begin
         if (rptr_ff == pvsd_pkg::PTR_W'(pvsd_pkg::WINDOW_LEN - 1)) begin
            rptr_in = '0;
         end else begin
            rptr_in = rptr_ff + pvsd_pkg::PTR_W'(1);
         end
      end
   end

   always_comb begin
      s4_in.kind    = in_beat.kind;
      s4_in.time_ms = in_beat.time_ms;
      s4_in.dev     = in_beat.dev;
      s4_in.addr    = rptr_ff;

      s5_in.kind    = s4_ff.kind;
      s5_in.time_ms = s4_ff.time_ms;
      if (s4_ff.kind == pvsd_pkg::KIND_SAMPLE) begin
         s5_in.sum = sum_ff - pvsd_pkg::SUM_W'(old_dev) + pvsd_pkg::SUM_W'(s4_ff.dev);
      end else begin
         s5_in.sum = sum_ff;
      end

      s6_in.kind    = s5_ff.kind;
      s6_in.time_ms = s5_ff.time_ms;
      s6_in.prod    = pvsd_pkg::DIVP_W'({s5_ff.sum, 4'b0000})
                    * pvsd_pkg::DIVP_W'(pvsd_pkg::DIV_MUL);
   end

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_ff <= s4_in;
      end
      if (s5_rdy) begin
         s5_ff <= s5_in;
      end
      if (s6_rdy) begin
         s6_ff <= s6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         rptr_ff   <= '0;
         sum_ff    <= '0;
      end else begin
         if (s4_rdy) begin
            s4_vld_ff <= in_vld;
         end
         if (s5_rdy) begin
            s5_vld_ff <= s4_vld_ff;
         end
         if (s6_rdy) begin
            s6_vld_ff <= s5_vld_ff;
         end
         rptr_ff <= rptr_in;
         if (commit) begin
            sum_ff <= s5_in.sum;
         end
      end
   end

   assign out_vld          = s6_vld_ff;
   assign out_beat.kind    = s6_ff.kind;
   assign out_beat.time_ms = s6_ff.time_ms;
   assign out_beat.level   = s6_ff.prod[pvsd_pkg::DIV_SH +: pvsd_pkg::LVL_W];

endmodule

@@ rtl/pvsd_track.sv @@
// Peak/valley tracker, cadence check, step counter and the result register.
module pvsd_track (
   input  logic               clock,
   input  logic               reset,
   input  pvsd_pkg::cfg_type  cfg,
   input  logic               in_vld,
   output logic               in_rdy,
   input  pvsd_pkg::lvl_type  in_beat,
   output logic               out_vld,
   input  logic               out_rdy,
   output pvsd_pkg::rsp_type  out_beat
);

   logic [pvsd_pkg::LVL_W-1:0]  peak_ff, peak_in;
   logic [pvsd_pkg::LVL_W-1:0]  valley_ff, valley_in;
   logic [pvsd_pkg::LVL_W-1:0]  level_ff, level_in;
   logic                        going_up_ff, going_up_in;
   logic                        armed_ff, armed_in;
   logic [pvsd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [pvsd_pkg::TIME_W-1:0] last_ms_ff, last_ms_in;
   logic                        out_vld_ff;
   pvsd_pkg::rsp_type           rsp_ff, rsp_in;

   logic [pvsd_pkg::LVL_W-1:0]  val;
   logic [pvsd_pkg::LVL_W-1:0]  swing;
   logic [pvsd_pkg::TIME_W-1:0] dt;
   logic                        step;
   logic                        take;

   assign in_rdy = !out_vld_ff || out_rdy;
   assign take   = in_rdy && in_vld;

   assign val   = in_beat.level;
   assign swing = {cfg.min_swing, 4'b0000};
   assign dt    = in_beat.time_ms - last_ms_ff;

   always_comb begin
      peak_in     = peak_ff;
      valley_in   = valley_ff;
      level_in    = level_ff;
      going_up_in = going_up_ff;
      armed_in    = armed_ff;
      cnt_in      = cnt_ff;
      last_ms_in  = last_ms_ff;
      step        = 1'b0;
      if (in_beat.kind == pvsd_pkg::KIND_CLEAR) begin
         cnt_in = '0;
      end else begin
         level_in = val;
         if (peak_ff == '0 && valley_ff == '0) begin
            // empty tracker: load both ends and do nothing else
            peak_in   = val;
            valley_in = val;
         end else if (going_up_ff) begin
            if (val > peak_ff) begin
               peak_in = val;
            end else if (peak_ff - val > swing) begin
               going_up_in = 1'b0;
               armed_in    = 1'b1;
               valley_in   = val;
            end
         end else begin
            if (val < valley_ff) begin
               valley_in = val;
            end else if (armed_ff && (val - valley_ff > swing)) begin
               if (dt > pvsd_pkg::TIME_W'(cfg.gap_lo_ms)
                     && dt < pvsd_pkg::TIME_W'(cfg.gap_hi_ms)) begin
                  cnt_in     = cnt_ff + pvsd_pkg::CNT_W'(1);
                  last_ms_in = in_beat.time_ms;
                  step       = 1'b1;
               end
               going_up_in = 1'b1;
               armed_in    = 1'b0;
               peak_in     = val;
               valley_in   = val;
            end
         end
      end
      rsp_in.step_total     = cnt_in;
      rsp_in.step_now       = step;
      rsp_in.smoothed_level = level_in;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         peak_ff     <= '0;
         valley_ff   <= '0;
         level_ff    <= '0;
         going_up_ff <= 1'b1;
         armed_ff    <= 1'b0;
         cnt_ff      <= '0;
         last_ms_ff  <= '0;
      end else begin
         if (in_rdy) begin
            out_vld_ff <= in_vld;
         end
         if (take) begin
            peak_ff     <= peak_in;
            valley_ff   <= valley_in;
            level_ff    <= level_in;
            going_up_ff <= going_up_in;
            armed_ff    <= armed_in;
            cnt_ff      <= cnt_in;
            last_ms_ff  <= last_ms_in;
         end
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_beat = rsp_ff;

endmodule

@@ rtl/peak_valley_step_detector.sv @@
// Peak/valley step detector: settings registers and the processing pipeline.
//
// req_* carries one beat per acceleration sample or clear request; req_tuser
// is 1 for a clear. rsp_* returns exactly one beat per request, in order,
// with the running step total, the step flag and the smoothed level. csr_*
// writes one settings register per cycle; the user must write only while the
// block is idle, which the block itself does not enforce.
// One request is accepted every cycle while rsp_tready is high; the window
// store is read as a request enters the read stage and written back as
// it leaves that stage, so the running-sum read-modify-write loop sets the
// one-per-cycle rate. The window store holds the last 8 deviations in a
// one-port-read memory.
//
// Reset clears the pipeline, the window (through per-entry valid bits, no
// clearing pass), the tracker and the step count, and loads the settings
// defaults. When the receiver holds rsp_tready low, each stage keeps its beat
// and req_tready drops once the pipeline has no empty stage left.
module peak_valley_step_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // accel_x[11:0], accel_y[23:12], accel_z[35:24], time_ms[67:36], zero pad
   input  logic [pvsd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type: 0 sample, 1 clear step count
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // step_total[31:0], step_now[32], smoothed_level[49:33], zero pad
   output logic [pvsd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [pvsd_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [pvsd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   pvsd_pkg::cfg_type    cfg_ff;
   pvsd_pkg::sample_type req_beat;
   pvsd_pkg::dev_type    dev_beat;
   pvsd_pkg::lvl_type    lvl_beat;
   pvsd_pkg::rsp_type    rsp_beat;
   logic dev_vld, dev_rdy, lvl_vld, lvl_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grav_x      <= 16'sd0;
         cfg_ff.grav_y      <= 16'sd0;
         cfg_ff.grav_z      <= 16'sd16384;
         cfg_ff.rest_level  <= 13'sd1000;
         cfg_ff.quiet_band  <= 13'd0;
         cfg_ff.min_swing   <= 13'd100;
         cfg_ff.gap_lo_ms   <= 16'd250;
         cfg_ff.gap_hi_ms   <= 16'd2000;
      end else if (csr_we) begin
         case (pvsd_pkg::csr_idx_type'(csr_addr))
            pvsd_pkg::CSR_GRAV_X: begin
               cfg_ff.grav_x <= csr_wdata;
            end
            pvsd_pkg::CSR_GRAV_Y: begin
               cfg_ff.grav_y <= csr_wdata;
            end
            pvsd_pkg::CSR_GRAV_Z: begin
               cfg_ff.grav_z <= csr_wdata;
            end
            pvsd_pkg::CSR_REST_LEVEL: begin
               cfg_ff.rest_level <= csr_wdata[pvsd_pkg::DEV_W-1:0];
            end
            pvsd_pkg::CSR_QUIET_BAND: begin
               cfg_ff.quiet_band <= csr_wdata[pvsd_pkg::DEV_W-1:0];
            end
            pvsd_pkg::CSR_MIN_SWING: begin
               cfg_ff.min_swing <= csr_wdata[pvsd_pkg::DEV_W-1:0];
            end
            pvsd_pkg::CSR_GAP_LO: begin
               cfg_ff.gap_lo_ms <= csr_wdata;
            end
            pvsd_pkg::CSR_GAP_HI: begin
               cfg_ff.gap_hi_ms <= csr_wdata;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      req_beat.kind    = pvsd_pkg::kind_type'(req_tuser);
      req_beat.accel_x = req_tdata[11:0];
      req_beat.accel_y = req_tdata[23:12];
      req_beat.accel_z = req_tdata[35:24];
      req_beat.time_ms = req_tdata[67:36];
   end

   pvsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_vld   (req_tvalid),
      .in_rdy   (req_tready),
      .in_beat  (req_beat),
      .out_vld  (dev_vld),
      .out_rdy  (dev_rdy),
      .out_beat (dev_beat)
   );

   pvsd_window u_window (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (dev_vld),
      .in_rdy   (dev_rdy),
      .in_beat  (dev_beat),
      .out_vld  (lvl_vld),
      .out_rdy  (lvl_rdy),
      .out_beat (lvl_beat)
   );

   pvsd_track u_track (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_vld   (lvl_vld),
      .in_rdy   (lvl_rdy),
      .in_beat  (lvl_beat),
      .out_vld  (rsp_tvalid),
      .out_rdy  (rsp_tready),
      .out_beat (rsp_beat)
   );

   assign rsp_tdata = {(pvsd_pkg::RSP_TDATA_W - $bits(pvsd_pkg::rsp_type))'(0), rsp_beat};

endmodule

@@ tb/pvsd_checker.sv @@
// Step detector scoreboard: tracks settings, predicts each result beat and compares.
`timescale 1ns / 1ps

module pvsd_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // accel_x[11:0], accel_y[23:12], accel_z[35:24], time_ms[67:36], zero pad
   input  logic [pvsd_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type: 0 sample, 1 clear step count
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // step_total[31:0], step_now[32], smoothed_level[49:33], zero pad
   input  logic [pvsd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [pvsd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [pvsd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                      fault_count,
   output int unsigned                      backlog
);

   logic signed [pvsd_pkg::GRAV_W-1:0] grav_x_q, grav_y_q, grav_z_q;
   logic signed [pvsd_pkg::DEV_W-1:0]  rest_q;
   logic [pvsd_pkg::DEV_W-1:0]         dead_q, swing_q;
   logic [15:0]                        cad_lo_q, cad_hi_q;

   logic [pvsd_pkg::DEV_W-1:0]  window_q [pvsd_pkg::WINDOW_LEN];
   int unsigned                 slot;
   logic [pvsd_pkg::SUM_W-1:0]  window_total;
   logic [pvsd_pkg::LVL_W-1:0]  peak_q, valley_q;
   bit                          rising, armed;
   logic [pvsd_pkg::CNT_W-1:0]  tally;
   logic [pvsd_pkg::TIME_W-1:0] last_step;

   pvsd_pkg::rsp_type tally_queue [$];
   int unsigned       faults = 0;

   function automatic logic [pvsd_pkg::DEV_W-1:0] deviation_mg(
         logic signed [pvsd_pkg::ACC_W-1:0] ax,
         logic signed [pvsd_pkg::ACC_W-1:0] ay,
         logic signed [pvsd_pkg::ACC_W-1:0] az);
      longint dot, proj, gap;
      dot = longint'(ax) * longint'(grav_x_q) + longint'(ay) * longint'(grav_y_q)
          + longint'(az) * longint'(grav_z_q);
      // round to nearest mg, ties up
      proj = (dot + 64'sd8192) >>> 14;
      gap = proj - longint'(rest_q);
      if (gap < 0) gap = -gap;
      if (gap < longint'(dead_q)) gap = 0;
      if (gap > longint'(pvsd_pkg::DEV_MAX)) gap = longint'(pvsd_pkg::DEV_MAX);
      return gap[pvsd_pkg::DEV_W-1:0];
   endfunction

   function automatic logic [pvsd_pkg::LVL_W-1:0] level_now();
      return pvsd_pkg::LVL_W'((64'(window_total) * 64'd16) / 64'(pvsd_pkg::WINDOW_LEN));
   endfunction

   function automatic bit follow_level(logic [pvsd_pkg::LVL_W-1:0] lvl,
                                       logic [pvsd_pkg::TIME_W-1:0] now);
      logic [31:0] swing, dt;
      bit step;
      swing = 32'({swing_q, 4'd0});
      step = 1'b0;
      // empty tracker: load both marks and do nothing else
      if (peak_q == '0 && valley_q == '0) begin
         peak_q = lvl;
         valley_q = lvl;
         return 1'b0;
      end
      if (rising) begin
         if (lvl > peak_q) begin
            peak_q = lvl;
         end else if (32'(peak_q - lvl) > swing) begin
            rising = 1'b0;
            armed = 1'b1;
            valley_q = lvl;
         end
      end else begin
         if (lvl < valley_q) begin
            valley_q = lvl;
         end else if (armed && 32'(lvl - valley_q) > swing) begin
            dt = now - last_step;
            if (dt > 32'(cad_lo_q) && dt < 32'(cad_hi_q)) begin
               tally = tally + pvsd_pkg::CNT_W'(1);
               last_step = now;
               step = 1'b1;
            end
            rising = 1'b1;
            armed = 1'b0;
            peak_q = lvl;
            valley_q = lvl;
         end
      end
      return step;
   endfunction

   function automatic pvsd_pkg::rsp_type predict_tally(
         pvsd_pkg::kind_type kind,
         logic signed [pvsd_pkg::ACC_W-1:0] ax,
         logic signed [pvsd_pkg::ACC_W-1:0] ay,
         logic signed [pvsd_pkg::ACC_W-1:0] az,
         logic [pvsd_pkg::TIME_W-1:0] now);
      pvsd_pkg::rsp_type r;
      logic [pvsd_pkg::DEV_W-1:0] dev;
      bit step;
      step = 1'b0;
      if (kind == pvsd_pkg::KIND_CLEAR) begin
         tally = '0;
      end else begin
         dev = deviation_mg(ax, ay, az);
         window_total = window_total - pvsd_pkg::SUM_W'(window_q[slot])
                      + pvsd_pkg::SUM_W'(dev);
         window_q[slot] = dev;
         slot = (slot + 1) % pvsd_pkg::WINDOW_LEN;
         step = follow_level(level_now(), now);
      end
      r.step_total = tally;
      r.step_now = step;
      r.smoothed_level = level_now();
      return r;
   endfunction

   task automatic note_fault(string what, pvsd_pkg::rsp_type want,
                             pvsd_pkg::rsp_type seen);
      faults++;
      if (faults <= 10)
         $display({"%0t checker: %s: expected total %0d step %0b level %0d,",
                   " got total %0d step %0b level %0d"},
                  $realtime, what, want.step_total, want.step_now, want.smoothed_level,
                  seen.step_total, seen.step_now, seen.smoothed_level);
   endtask

   always @(posedge clock) begin : watch
      pvsd_pkg::rsp_type seen, want;
      if (reset) begin
         grav_x_q = '0;
         grav_y_q = '0;
         grav_z_q = 16'sd16384;
         rest_q = 13'sd1000;
         dead_q = '0;
         swing_q = 13'd100;
         cad_lo_q = 16'd250;
         cad_hi_q = 16'd2000;
         foreach (window_q[i]) window_q[i] = '0;
         slot = 0;
         window_total = '0;
         peak_q = '0;
         valley_q = '0;
         rising = 1'b1;
         armed = 1'b0;
         tally = '0;
         last_step = '0;
         tally_queue.delete();
      end else begin
         if (csr_we) begin
            case (pvsd_pkg::csr_idx_type'(csr_addr))
               pvsd_pkg::CSR_GRAV_X:     grav_x_q = csr_wdata;
               pvsd_pkg::CSR_GRAV_Y:     grav_y_q = csr_wdata;
               pvsd_pkg::CSR_GRAV_Z:     grav_z_q = csr_wdata;
               pvsd_pkg::CSR_REST_LEVEL: rest_q = csr_wdata[pvsd_pkg::DEV_W-1:0];
               pvsd_pkg::CSR_QUIET_BAND: dead_q = csr_wdata[pvsd_pkg::DEV_W-1:0];
               pvsd_pkg::CSR_MIN_SWING:  swing_q = csr_wdata[pvsd_pkg::DEV_W-1:0];
               pvsd_pkg::CSR_GAP_LO:     cad_lo_q = csr_wdata;
               pvsd_pkg::CSR_GAP_HI:     cad_hi_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = pvsd_pkg::rsp_type'(rsp_tdata[$bits(pvsd_pkg::rsp_type)-1:0]);
            if (tally_queue.size() == 0) begin
               want = '0;
               note_fault("unexpected beat", want, seen);
            end else begin
               want = tally_queue.pop_front();
               if (seen !== want) note_fault("mismatch", want, seen);
            end
         end
         if (req_tvalid && req_tready)
            tally_queue.push_back(predict_tally(pvsd_pkg::kind_type'(req_tuser),
                                                req_tdata[11:0], req_tdata[23:12],
                                                req_tdata[35:24], req_tdata[67:36]));
      end
      fault_count <= faults;
      backlog <= tally_queue.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the step detector bench: clock, reset, settings, sample stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int STALL_LIMIT = 2000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pvsd_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [pvsd_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [pvsd_pkg::CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [pvsd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned  fault_count, backlog;
   int unsigned  quiet_cycles = 0;
   bit           calm = 1'b0;
   logic [31:0]  stamp_ms = '0;

   peak_valley_step_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   pvsd_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fault_count (fault_count),
      .backlog     (backlog)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 17);
   end

   // end the run when no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic logic signed [pvsd_pkg::ACC_W-1:0] clamp_accel(int v);
      if (v < -2000) v = -2000;
      if (v > 1999) v = 1999;
      return pvsd_pkg::ACC_W'(v);
   endfunction

   function automatic logic signed [pvsd_pkg::ACC_W-1:0] pick_accel();
      case ($urandom_range(3))
         0:       return -12'sd2000;
         1:       return 12'sd1999;
         default: return pvsd_pkg::ACC_W'(pick(-2000, 1999));
      endcase
   endfunction

   task automatic issue(pvsd_pkg::kind_type kind, logic signed [pvsd_pkg::ACC_W-1:0] ax,
                        logic signed [pvsd_pkg::ACC_W-1:0] ay,
                        logic signed [pvsd_pkg::ACC_W-1:0] az,
                        logic [pvsd_pkg::TIME_W-1:0] at_ms);
      if (!calm && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 17);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= pvsd_pkg::REQ_TDATA_W'({at_ms, az, ay, ax});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sample(int ax, int ay, int az, logic [pvsd_pkg::TIME_W-1:0] at_ms);
      issue(pvsd_pkg::KIND_SAMPLE, clamp_accel(ax), clamp_accel(ay), clamp_accel(az),
            at_ms);
   endtask

   // drop valid, wait for every result, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(pvsd_pkg::csr_idx_type idx, int value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= pvsd_pkg::CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic load_settings(int gx, int gy, int gz, int rest_mg, int dead, int swing,
                                int cad_lo, int cad_hi);
      write_reg(pvsd_pkg::CSR_GRAV_X, gx);
      write_reg(pvsd_pkg::CSR_GRAV_Y, gy);
      write_reg(pvsd_pkg::CSR_GRAV_Z, gz);
      write_reg(pvsd_pkg::CSR_REST_LEVEL, rest_mg);
      write_reg(pvsd_pkg::CSR_QUIET_BAND, dead);
      write_reg(pvsd_pkg::CSR_MIN_SWING, swing);
      write_reg(pvsd_pkg::CSR_GAP_LO, cad_lo);
      write_reg(pvsd_pkg::CSR_GAP_HI, cad_hi);
      csr_we <= 1'b0;
   endtask

   // triangle wave on z around the rest level or wholly below it, like a walker's bounce
   task automatic walk(int count, int rest_mg);
      int period, amp, offset, dt_lo, dt_hi, pos, ramp;
      period = pick(10, 40);
      amp = pick(200, 700);
      offset = $urandom_range(1) ? amp + 20 : 0;
      dt_lo = pick(8, 25);
      dt_hi = dt_lo + pick(0, 20);
      for (int i = 0; i < count; i++) begin
         stamp_ms = stamp_ms + 32'(pick(dt_lo, dt_hi));
         pos = i % period;
         if (2 * pos < period)
            ramp = 4 * pos * amp / period - amp;
         else
            ramp = 3 * amp - 4 * pos * amp / period;
         if ($urandom_range(99) < 4)
            issue(pvsd_pkg::KIND_CLEAR, pick_accel(), pick_accel(), pick_accel(), stamp_ms);
         else
            sample(pick(-50, 50), pick(-50, 50), rest_mg - offset + ramp, stamp_ms);
      end
   endtask

   task automatic noise(int count);
      pvsd_pkg::kind_type kind;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1))
            stamp_ms = stamp_ms + 32'(pick(0, 600));
         else
            stamp_ms = $urandom;
         kind = ($urandom_range(99) < 8) ? pvsd_pkg::KIND_CLEAR : pvsd_pkg::KIND_SAMPLE;
         issue(kind, pick_accel(), pick_accel(), pick_accel(), stamp_ms);
      end
   endtask

   initial begin
      int cad_lo;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes, clears, time extremes
      issue(pvsd_pkg::KIND_CLEAR, '0, '0, '0, '0);
      sample(0, 0, 0, 0);
      sample(-2000, -2000, -2000, 1);
      sample(1999, 1999, 1999, 2);
      sample(-2000, 1999, 0, 3);
      issue(pvsd_pkg::KIND_CLEAR, -12'sd1, -12'sd1, -12'sd1, 32'hFFFF_FFFF);
      sample(0, 0, 1000, 100);
      sample(0, 0, -2000, 32'hFFFF_FFFF);
      sample(1999, -2000, 1999, 32'h8000_0000);
      sample(0, 0, 1600, 400);
      sample(0, 0, 1800, 420);
      sample(0, 0, 1000, 440);
      sample(0, 0, 1000, 460);
      sample(0, 0, 1900, 700);
      sample(0, 0, 1000, 720);
      issue(pvsd_pkg::KIND_CLEAR, '0, '0, '0, 730);
      settle();

      // reset-like settings, no idling on either side
      calm = 1'b1;
      load_settings(0, 0, 16384, 1000, 0, 100, 250, 2000);
      stamp_ms = '0;
      walk(60, 1000);
      walk(60, 1000);
      settle();
      calm = 1'b0;

      // saturating deviation under the widest dead band, no step possible
      load_settings(16384, 16384, 16384, -4096, 8191, 8191, 65535, 0);
      noise(60);
      settle();

      load_settings(-16384, -16384, -16384, 4095, 0, 0, 0, 65535);
      noise(80);
      settle();

      // equal cadence bounds: the tracker turns but never counts
      load_settings(0, 0, 16384, 1000, 0, 100, 1000, 1000);
      walk(80, 1000);
      settle();

      repeat (4) begin
         cad_lo = pick(0, 500);
         load_settings(pick(-16384, 16384), pick(-16384, 16384), pick(-16384, 16384),
                       pick(-4096, 4095), pick(0, 150), pick(0, 150), cad_lo,
                       pick(cad_lo, 3000));
         walk(50, pick(-500, 1000));
         noise(30);
         settle();
      end

      // step intervals starting just before the timestamp wrap, which a slow walk crosses
      load_settings(0, 0, 16384, 1000, 20, 60, 200, 1500);
      stamp_ms = 32'hFFFF_F800;
      walk(80, 1000);
      settle();

      if (fault_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

@@ files.f @@
rtl/pvsd_pkg.sv
rtl/pvsd_front.sv
rtl/pvsd_wmem.sv
rtl/pvsd_window.sv
rtl/pvsd_track.sv
rtl/peak_valley_step_detector.sv
tb/pvsd_checker.sv
tb/testbench.sv
